// ----- rtl/sprq_pkg.sv -----
package sprq_pkg;

  localparam int PRIO_LEVELS = 4;
  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_RESULTS = 64;
  localparam int CMDQ_DEPTH  = 2;

  localparam int LVL_W   = $clog2(PRIO_LEVELS);
  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int NSLOTS  = PRIO_LEVELS * QUEUE_DEPTH;
  localparam int ADDR_W  = $clog2(NSLOTS);
  localparam int TOT_W   = $clog2(NSLOTS + 1);
  localparam int CNT_W   = $clog2(MAX_RESULTS + 1);
  localparam int CQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  localparam logic [1:0] HB_LEVEL_RST     = 2'd3;
  localparam logic [15:0] INLINE_LIMIT_RST = 16'd64;

  typedef enum logic [1:0] {
    KIND_SUBMIT = 2'd0,
    KIND_POP    = 2'd1,
    KIND_FLUSH  = 2'd2
  } sprq_kind_e;

  typedef enum logic [1:0] {
    OP_SUBMIT,
    OP_POP,
    OP_FLUSH,
    OP_BAD
  } sprq_op_e;

  typedef enum logic [3:0] {
    ST_ACCEPTED    = 4'd0,
    ST_DROPPED     = 4'd1,
    ST_INVALID     = 4'd2,
    ST_FULL        = 4'd3,
    ST_STOPPED     = 4'd4,
    ST_POPPED      = 4'd5,
    ST_EMPTY       = 4'd6,
    ST_INTERRUPTED = 4'd7,
    ST_FLUSH_NONE  = 4'd8
  } sprq_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP_RD,
    S_FLUSH,
    S_FLUSH_RD
  } sprq_state_e;

  typedef enum logic {
    REG_HB_LEVEL     = 1'b0,
    REG_INLINE_LIMIT = 1'b1
  } sprq_reg_e;

  // classified command handed from front to back
  typedef struct packed {
    sprq_op_e          op;
    logic              lvl_ok;
    logic              req_ok;
    logic [LVL_W-1:0]  lvl;
    logic [15:0]       length;
    logic              has_completion;
    logic [7:0]        endpoint;
    logic              use_interrupt;
    logic [31:0]       xfer_tmo;
    logic [31:0]       descriptor;
  } cmd_t;

  typedef struct packed {
    logic  valid;
    cmd_t  cmd;
  } cmd_link_t;

  typedef struct packed {
    logic [31:0] serial;
    logic        has_completion;
    logic [31:0] descriptor;
    logic [31:0] xfer_tmo;
    logic        use_interrupt;
    logic [7:0]  endpoint;
    logic [15:0] length;
  } entry_t;

  typedef struct packed {
    sprq_status_e status;
    logic [1:0]   out_priority;
    logic [15:0]  out_length;
    logic [7:0]   out_endpoint;
    logic         out_use_interrupt;
    logic [31:0]  out_xfer_tmo;
    logic [31:0]  out_descriptor;
    logic         out_has_completion;
    logic [31:0]  serial;
    logic [31:0]  drop_count;
    logic         last;
  } rsp_t;

  function automatic rsp_t mk_rsp(sprq_status_e st, logic [31:0] drops);
    rsp_t r;
    r            = '0;
    r.status     = st;
    r.drop_count = drops;
    r.last       = 1'b1;
    return r;
  endfunction

  function automatic rsp_t entry_rsp(sprq_status_e st, logic [LVL_W-1:0] lvl,
                                     logic [31:0] drops, entry_t e, logic last);
    rsp_t r;
    r                    = mk_rsp(st, drops);
    r.out_priority       = 2'(lvl);
    r.out_length         = e.length;
    r.out_endpoint       = e.endpoint;
    r.out_use_interrupt  = e.use_interrupt;
    r.out_xfer_tmo       = e.xfer_tmo;
    r.out_descriptor     = e.descriptor;
    r.out_has_completion = e.has_completion;
    r.serial             = e.serial;
    r.last               = last;
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(logic [LVL_W-1:0] lvl,
                                                  logic [PTR_W-1:0] ptr);
    return ADDR_W'(lvl) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(ptr);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

// ----- rtl/sprq_req_if.sv -----
interface sprq_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  priority_req;
  logic [15:0] length;
  logic        has_data;
  logic        has_completion;
  logic [7:0]  endpoint;
  logic        use_interrupt;
  logic [31:0] xfer_tmo;
  logic [31:0] descriptor;

  modport source (
    output valid, kind, priority_req, length, has_data, has_completion,
           endpoint, use_interrupt, xfer_tmo, descriptor,
    input  ready
  );
  modport sink (
    input  valid, kind, priority_req, length, has_data, has_completion,
           endpoint, use_interrupt, xfer_tmo, descriptor,
    output ready
  );
endinterface

// ----- rtl/sprq_rsp_if.sv -----
interface sprq_rsp_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [1:0]  out_priority;
  logic [15:0] out_length;
  logic [7:0]  out_endpoint;
  logic        out_use_interrupt;
  logic [31:0] out_xfer_tmo;
  logic [31:0] out_descriptor;
  logic        out_has_completion;
  logic [31:0] serial;
  logic [31:0] drop_count;
  logic        last;

  modport source (
    output valid, status, out_priority, out_length, out_endpoint, out_use_interrupt,
           out_xfer_tmo, out_descriptor, out_has_completion, serial, drop_count, last,
    input  ready
  );
  modport sink (
    input  valid, status, out_priority, out_length, out_endpoint, out_use_interrupt,
           out_xfer_tmo, out_descriptor, out_has_completion, serial, drop_count, last,
    output ready
  );
endinterface

// ----- rtl/sprq_front.sv -----
module sprq_front
  import sprq_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [15:0]      inline_limit_i,
  sprq_req_if.sink         req,
  output cmd_link_t        cmd_o,
  input  logic             cmd_take_i
);

  cmd_t                cq_q [CMDQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CQ_CNT_W-1:0] cnt_q, cnt_d;
  logic                push, pop;
  cmd_t                cls;

  assign req.ready = (cnt_q != CQ_CNT_W'(CMDQ_DEPTH));
  assign push      = req.valid && req.ready;
  assign pop       = cmd_take_i && (cnt_q != '0);

  always_comb begin
    cls                = '0;
    case (req.kind)
      KIND_SUBMIT: cls.op = OP_SUBMIT;
      KIND_POP:    cls.op = OP_POP;
      KIND_FLUSH:  cls.op = OP_FLUSH;
      default:     cls.op = OP_BAD;
    endcase
    cls.lvl_ok         = ({1'b0, req.priority_req} < 4'(PRIO_LEVELS));
    // long payloads need a completion record
    cls.req_ok         = cls.lvl_ok && req.has_data && (req.length != '0) &&
                         ((req.length <= inline_limit_i) || req.has_completion);
    cls.lvl            = LVL_W'(req.priority_req);
    cls.length         = req.length;
    cls.has_completion = req.has_completion;
    cls.endpoint       = req.endpoint;
    cls.use_interrupt  = req.use_interrupt;
    cls.xfer_tmo       = req.xfer_tmo;
    cls.descriptor     = req.descriptor;
  end

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == CQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == CQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      cq_q[wr_q] <= cls;
    end
  end

  assign cmd_o.valid = (cnt_q != '0);
  assign cmd_o.cmd   = cq_q[rd_q];

endmodule

// ----- rtl/sprq_back.sv -----
module sprq_back
  import sprq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [1:0]  hb_level_i,
  input  cmd_link_t   cmd_i,
  output logic        cmd_take_o,
  sprq_rsp_if.source  rsp
);

  sprq_state_e       state_q, state_d;
  logic [PTR_W-1:0]  wp_q [PRIO_LEVELS];
  logic [PTR_W-1:0]  wp_d [PRIO_LEVELS];
  logic [PTR_W-1:0]  rp_q [PRIO_LEVELS];
  logic [PTR_W-1:0]  rp_d [PRIO_LEVELS];
  logic [FILL_W-1:0] fill_q [PRIO_LEVELS];
  logic [FILL_W-1:0] fill_d [PRIO_LEVELS];
  logic [31:0]       drop_q [PRIO_LEVELS];
  logic [31:0]       drop_d [PRIO_LEVELS];
  logic [31:0]       serial_q, serial_d;
  logic              stopped_q, stopped_d;
  logic [LVL_W-1:0]  lvl_q, lvl_d;
  logic [31:0]       dlat_q, dlat_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  lim_q, lim_d;
  logic              ov_q, ov_d;
  rsp_t              res_q, res_d;

  entry_t            mem_q [NSLOTS];
  entry_t            rd_q;
  entry_t            wdata;
  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;

  logic              out_free;
  logic              found;
  logic [LVL_W-1:0]  sel;
  logic [TOT_W-1:0]  total;
  logic              load;
  rsp_t              new_rsp;
  logic              flush_last;
  logic [LVL_W-1:0]  lv;

  assign out_free   = !ov_q || rsp.ready;
  assign cmd_take_o = (state_q == S_IDLE) && cmd_i.valid && out_free;
  assign lv         = cmd_i.cmd.lvl;
  assign flush_last = (cnt_q == lim_q);

  // lowest-numbered nonempty level and total backlog
  always_comb begin
    found = 1'b0;
    sel   = '0;
    total = '0;
    for (int l = PRIO_LEVELS - 1; l >= 0; l--) begin
      if (fill_q[l] != '0) begin
        found = 1'b1;
        sel   = LVL_W'(l);
      end
    end
    for (int l = 0; l < PRIO_LEVELS; l++) begin
      total = total + TOT_W'(fill_q[l]);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_take_o) begin
          if (cmd_i.cmd.op == OP_POP && found) begin
            state_d = S_POP_RD;
          end else if (cmd_i.cmd.op == OP_FLUSH && total != '0) begin
            state_d = S_FLUSH;
          end
        end
      end
      S_POP_RD:   state_d = S_IDLE;
      S_FLUSH: begin
        if (out_free) begin
          state_d = S_FLUSH_RD;
        end
      end
      S_FLUSH_RD: state_d = flush_last ? S_IDLE : S_FLUSH;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    wp_d      = wp_q;
    rp_d      = rp_q;
    fill_d    = fill_q;
    drop_d    = drop_q;
    serial_d  = serial_q;
    stopped_d = stopped_q;
    lvl_d     = lvl_q;
    dlat_d    = dlat_q;
    cnt_d     = cnt_q;
    lim_d     = lim_q;
    we        = 1'b0;
    re        = 1'b0;
    waddr     = slot_addr(lv, wp_q[lv]);
    raddr     = slot_addr(sel, rp_q[sel]);
    load      = 1'b0;
    new_rsp   = mk_rsp(ST_INVALID, '0);
    wdata.serial         = serial_q + 32'd1;
    wdata.has_completion = cmd_i.cmd.has_completion;
    wdata.descriptor     = cmd_i.cmd.descriptor;
    wdata.xfer_tmo       = cmd_i.cmd.xfer_tmo;
    wdata.use_interrupt  = cmd_i.cmd.use_interrupt;
    wdata.endpoint       = cmd_i.cmd.endpoint;
    wdata.length         = cmd_i.cmd.length;
    case (state_q)
      S_IDLE: begin
        if (cmd_take_o) begin
          case (cmd_i.cmd.op)
            OP_SUBMIT: begin
              load = 1'b1;
              if (!cmd_i.cmd.req_ok) begin
                new_rsp = mk_rsp(ST_INVALID, cmd_i.cmd.lvl_ok ? drop_q[lv] : '0);
              end else if (stopped_q) begin
                new_rsp = mk_rsp(ST_STOPPED, drop_q[lv]);
              end else if (fill_q[lv] == FILL_W'(QUEUE_DEPTH)) begin
                if (2'(lv) == hb_level_i) begin
                  drop_d[lv] = drop_q[lv] + 32'd1;
                  new_rsp    = mk_rsp(ST_DROPPED, drop_q[lv] + 32'd1);
                end else begin
                  new_rsp = mk_rsp(ST_FULL, drop_q[lv]);
                end
              end else begin
                we             = 1'b1;
                serial_d       = serial_q + 32'd1;
                wp_d[lv]       = ptr_inc(wp_q[lv]);
                fill_d[lv]     = fill_q[lv] + 1'b1;
                new_rsp        = mk_rsp(ST_ACCEPTED, drop_q[lv]);
                new_rsp.serial = serial_q + 32'd1;
              end
            end
            OP_POP: begin
              if (found) begin
                re          = 1'b1;
                rp_d[sel]   = ptr_inc(rp_q[sel]);
                fill_d[sel] = fill_q[sel] - 1'b1;
                lvl_d       = sel;
                dlat_d      = drop_q[sel];
              end else begin
                load    = 1'b1;
                new_rsp = mk_rsp(ST_EMPTY, '0);
              end
            end
            OP_FLUSH: begin
              stopped_d = 1'b1;
              cnt_d     = '0;
              lim_d     = (total > TOT_W'(MAX_RESULTS)) ? CNT_W'(MAX_RESULTS)
                                                         : CNT_W'(total);
              if (total == '0) begin
                load    = 1'b1;
                new_rsp = mk_rsp(ST_FLUSH_NONE, '0);
              end
            end
            default: begin
              load    = 1'b1;
              new_rsp = mk_rsp(ST_INVALID, '0);
            end
          endcase
        end
      end
      S_POP_RD: begin
        load    = 1'b1;
        new_rsp = entry_rsp(ST_POPPED, lvl_q, dlat_q, rd_q, 1'b1);
      end
      S_FLUSH: begin
        if (out_free) begin
          re          = 1'b1;
          rp_d[sel]   = ptr_inc(rp_q[sel]);
          fill_d[sel] = fill_q[sel] - 1'b1;
          lvl_d       = sel;
          dlat_d      = drop_q[sel];
          cnt_d       = cnt_q + 1'b1;
        end
      end
      S_FLUSH_RD: begin
        load    = 1'b1;
        new_rsp = entry_rsp(ST_INTERRUPTED, lvl_q, dlat_q, rd_q, flush_last);
        // result budget spent: whatever is left is discarded
        if (flush_last) begin
          for (int l = 0; l < PRIO_LEVELS; l++) begin
            rp_d[l]   = wp_q[l];
            fill_d[l] = '0;
          end
        end
      end
      default: ;
    endcase
  end

  assign ov_d  = load || (ov_q && !rsp.ready);
  assign res_d = load ? new_rsp : res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      serial_q  <= '0;
      stopped_q <= 1'b0;
      ov_q      <= 1'b0;
      cnt_q     <= '0;
      lim_q     <= '0;
      for (int l = 0; l < PRIO_LEVELS; l++) begin
        wp_q[l]   <= '0;
        rp_q[l]   <= '0;
        fill_q[l] <= '0;
        drop_q[l] <= '0;
      end
    end else begin
      state_q   <= state_d;
      serial_q  <= serial_d;
      stopped_q <= stopped_d;
      ov_q      <= ov_d;
      cnt_q     <= cnt_d;
      lim_q     <= lim_d;
      wp_q      <= wp_d;
      rp_q      <= rp_d;
      fill_q    <= fill_d;
      drop_q    <= drop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q  <= lvl_d;
    dlat_q <= dlat_d;
    res_q  <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem_q[raddr];
    end
  end

  assign rsp.valid              = ov_q;
  assign rsp.status             = res_q.status;
  assign rsp.out_priority       = res_q.out_priority;
  assign rsp.out_length         = res_q.out_length;
  assign rsp.out_endpoint       = res_q.out_endpoint;
  assign rsp.out_use_interrupt  = res_q.out_use_interrupt;
  assign rsp.out_xfer_tmo       = res_q.out_xfer_tmo;
  assign rsp.out_descriptor     = res_q.out_descriptor;
  assign rsp.out_has_completion = res_q.out_has_completion;
  assign rsp.serial             = res_q.serial;
  assign rsp.drop_count         = res_q.drop_count;
  assign rsp.last               = res_q.last;

endmodule

// ----- rtl/strict_priority_ring_queues.sv -----
// Channel   Dir  Handshake       Payload
// req_i     in   valid/ready     kind, priority_req, length, flags, endpoint, timeout, descr
// rsp_o     out  valid/ready     status, entry fields, serial, drop_count, last
// apb       in   psel/penable    heartbeat_level @0x0, inline_limit @0x4
//
// Items pass a two-entry command queue; the back end takes one when idle with its output
// register free. Submit, reject and empty-pop are answered from idle; a pop reads the entry
// memory, then loads the result. A flush returns up to 64 queued entries, each read, then
// loaded; it discards the rest. Reset clears pointers, counts, drop counters and serial,
// not the entry memory. A stalled output holds the back end; the queue accepts until full.
module strict_priority_ring_queues
  import sprq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  sprq_req_if.sink    req_i,
  sprq_rsp_if.source  rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [1:0]  hb_level_q;
  logic [15:0] inline_limit_q;
  cmd_link_t   cmd;
  logic        cmd_take;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hb_level_q     <= HB_LEVEL_RST;
      inline_limit_q <= INLINE_LIMIT_RST;
    end else if (cfg_wr) begin
      case (sprq_reg_e'(paddr[2]))
        REG_HB_LEVEL:     hb_level_q     <= pwdata[1:0];
        REG_INLINE_LIMIT: inline_limit_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sprq_reg_e'(paddr[2]))
      REG_HB_LEVEL:     prdata = {30'd0, hb_level_q};
      REG_INLINE_LIMIT: prdata = {16'd0, inline_limit_q};
      default:          prdata = '0;
    endcase
  end

  sprq_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .inline_limit_i (inline_limit_q),
    .req            (req_i),
    .cmd_o          (cmd),
    .cmd_take_i     (cmd_take)
  );

  sprq_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .hb_level_i (hb_level_q),
    .cmd_i      (cmd),
    .cmd_take_o (cmd_take),
    .rsp        (rsp_o)
  );

  a_take_needs_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_take |-> cmd.valid)
    else $error("back end took a command from an empty queue");

  a_only_flush_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.last) |-> (rsp_o.status == ST_INTERRUPTED))
    else $error("non-final result that is not a flushed entry");

  a_reject_no_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status == ST_DROPPED || rsp_o.status == ST_INVALID ||
                     rsp_o.status == ST_FULL || rsp_o.status == ST_STOPPED ||
                     rsp_o.status == ST_EMPTY || rsp_o.status == ST_FLUSH_NONE))
    |-> (rsp_o.serial == '0 && rsp_o.out_length == '0))
    else $error("rejected item carries entry data");

endmodule
